FILE: src/pet_pkg.sv
package pet_pkg;

	// fixed widths of the data path
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int PIXEL_BITS    = 8;
	localparam int MAX_HEIGHT    = 4096;
	localparam int COL_BITS      = 12;
	localparam int ROW_BITS      = 14;
	localparam int GEO_BITS      = 13;
	localparam int POS_BITS      = 25;
	localparam int MAG_BITS      = 21;
	localparam int THR_BITS      = 11;
	localparam int THR2_BITS     = 22;
	localparam int CFG_DATA_BITS = 13;
	localparam int FIFO_DEPTH    = 8;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LOW    = 2'd2,
		REG_HIGH   = 2'd3
	} reg_idx_t;

	// gradient direction sectors
	typedef enum logic [1:0] {
		SECT_HORZ = 2'd0,
		SECT_VERT = 2'd1,
		SECT_DIAG = 2'd2,
		SECT_ANTI = 2'd3
	} sector_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] grey;
		sector_t               sector;
		logic [MAG_BITS-1:0]   m2;
	} mag_entry_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] grey;
		logic                  fin;
		logic                  faint;
		logic                  keep;
	} surv_entry_t;

	// position of a window center plus the frame geometry it belongs to
	typedef struct packed {
		logic [GEO_BITS-1:0]        w;
		logic [GEO_BITS-1:0]        h;
		logic [COL_BITS-1:0]        col;
		logic signed [ROW_BITS-1:0] row;
		logic                       res;
		logic                       last;
	} pos_t;

	// step a raster position back by one row and one column
	function automatic pos_t center_of(pos_t p);
		pos_t c;
		c = p;
		if (p.col == '0) begin
			c.col = COL_BITS'(p.w - GEO_BITS'(1));
			c.row = p.row - ROW_BITS'(2);
		end else begin
			c.col = p.col - COL_BITS'(1);
			c.row = p.row - ROW_BITS'(1);
		end
		return c;
	endfunction

endpackage

FILE: src/pet_window.sv
module pet_window import pet_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int DATA_W    = PIXEL_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  logic [DATA_W-1:0] in_data,
	input  pos_t              in_pos,
	output logic              win_v,
	output logic [DATA_W-1:0] win [3][3],
	output pos_t              win_pos
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [DATA_W-1:0] row1_mem [MAX_WIDTH];
	logic [DATA_W-1:0] row2_mem [MAX_WIDTH];
	logic [DATA_W-1:0] rd1_s1, rd2_s1, data_s1;
	pos_t              pos_s1;
	logic              vld_s1, win_v_q;
	logic [DATA_W-1:0] win_q [3][3];
	pos_t              win_pos_q;

	// line buffers: read the two rows above, store the new value
	always_ff @(posedge clk) begin
		if (in_v) begin
			rd1_s1                     <= row1_mem[in_pos.col[AW-1:0]];
			rd2_s1                     <= row2_mem[in_pos.col[AW-1:0]];
			row1_mem[in_pos.col[AW-1:0]] <= in_data;
			data_s1                    <= in_data;
			pos_s1                     <= in_pos;
		end
		if (vld_s1) begin
			row2_mem[pos_s1.col[AW-1:0]] <= rd1_s1;
		end
	end

	// advance the strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			win_v_q <= 1'b0;
		end else begin
			vld_s1  <= in_v;
			win_v_q <= vld_s1;
		end
	end

	// shift the 3x3 window by one column
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd2_s1;
			win_q[1][2] <= rd1_s1;
			win_q[2][2] <= data_s1;
			win_pos_q   <= center_of(pos_s1);
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				win[r][c] = win_q[r][c];
			end
		end
	end

	assign win_v   = win_v_q;
	assign win_pos = win_pos_q;

endmodule

FILE: src/pet_grad.sv
module pet_grad import pet_pkg::*; (
	input  logic [PIXEL_BITS-1:0] px [3][3],
	input  pos_t                  pos,
	output mag_entry_t            ent
);

	logic                       top_z, bot_z, left_z, right_z;
	logic signed [ROW_BITS-1:0] last_row;
	logic [PIXEL_BITS-1:0]      q [3][3];
	logic [9:0]                 sum_l, sum_r, sum_t, sum_b;
	logic signed [10:0]         gx, gy;
	logic [10:0]                ngx, ngy;
	logic [9:0]                 ax, ay;
	logic [19:0]                axx, ayy;
	logic [10:0]                axy;
	logic [21:0]                s2;
	logic                       gx_pos, gy_pos;

	// zero the taps that fall outside the frame
	assign last_row = $signed({1'b0, pos.h - GEO_BITS'(1)});
	assign top_z    = (pos.row == '0);
	assign bot_z    = (pos.row == last_row);
	assign left_z   = (pos.col == '0);
	assign right_z  = ({1'b0, pos.col} == (pos.w - GEO_BITS'(1)));

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				q[r][c] = px[r][c];
				if ((r == 0 && top_z) || (r == 2 && bot_z) ||
				    (c == 0 && left_z) || (c == 2 && right_z)) begin
					q[r][c] = '0;
				end
			end
		end
	end

	// Prewitt sums
	assign sum_l = {2'b0, q[0][0]} + {2'b0, q[1][0]} + {2'b0, q[2][0]};
	assign sum_r = {2'b0, q[0][2]} + {2'b0, q[1][2]} + {2'b0, q[2][2]};
	assign sum_t = {2'b0, q[0][0]} + {2'b0, q[0][1]} + {2'b0, q[0][2]};
	assign sum_b = {2'b0, q[2][0]} + {2'b0, q[2][1]} + {2'b0, q[2][2]};
	assign gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
	assign gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	assign ngx   = -gx;
	assign ngy   = -gy;
	assign ax    = gx[10] ? ngx[9:0] : gx[9:0];
	assign ay    = gy[10] ? ngy[9:0] : gy[9:0];

	// squared magnitude and the sector test
	assign axx    = ax * ax;
	assign ayy    = ay * ay;
	assign axy    = {1'b0, ax} + {1'b0, ay};
	assign s2     = axy * axy;
	assign gx_pos = !gx[10] && (gx != '0);
	assign gy_pos = !gy[10] && (gy != '0);

	always_comb begin
		ent.grey = px[1][1];
		ent.m2   = {1'b0, axx} + {1'b0, ayy};
		if (ax == '0) begin
			ent.sector = SECT_VERT;
		end else if (s2 < {1'b0, axx, 1'b0}) begin
			ent.sector = SECT_HORZ;
		end else if (s2 < {1'b0, ayy, 1'b0}) begin
			ent.sector = SECT_VERT;
		end else if (gx_pos == gy_pos) begin
			ent.sector = SECT_DIAG;
		end else begin
			ent.sector = SECT_ANTI;
		end
	end

endmodule

FILE: src/pet_nms.sv
module pet_nms import pet_pkg::*; (
	input  mag_entry_t             mw [3][3],
	input  pos_t                   pos,
	input  logic [THR2_BITS-1:0]   low2,
	input  logic [THR2_BITS-1:0]   high2,
	output surv_entry_t            ent
);

	logic                       border;
	logic signed [ROW_BITS-1:0] last_row;
	logic [MAG_BITS-1:0]        m2, n1, n2;
	logic [THR2_BITS-1:0]       m2x;

	assign last_row = $signed({1'b0, pos.h - GEO_BITS'(1)});
	assign border   = (pos.row == '0) || (pos.row == last_row) || (pos.col == '0) ||
	                  ({1'b0, pos.col} == (pos.w - GEO_BITS'(1)));
	assign m2       = mw[1][1].m2;
	assign m2x      = {1'b0, m2};

	// pick the two neighbors along the gradient
	always_comb begin
		case (mw[1][1].sector)
			SECT_HORZ: begin
				n1 = mw[1][0].m2;
				n2 = mw[1][2].m2;
			end
			SECT_VERT: begin
				n1 = mw[0][1].m2;
				n2 = mw[2][1].m2;
			end
			SECT_DIAG: begin
				n1 = mw[0][0].m2;
				n2 = mw[2][2].m2;
			end
			default: begin
				n1 = mw[0][2].m2;
				n2 = mw[2][0].m2;
			end
		endcase
	end

	// border pixels keep their grey value as is
	always_comb begin
		ent.grey = mw[1][1].grey;
		ent.fin  = 1'b0;
		if (border) begin
			ent.faint = 1'b0;
			ent.keep  = (mw[1][1].grey != '0);
		end else begin
			ent.faint = (m2x > low2) && (m2x < high2);
			ent.keep  = (m2 >= n1) && (m2 >= n2) && (m2x >= low2) &&
			            (mw[1][1].grey != '0);
		end
	end

endmodule

FILE: src/pet_hyst.sv
module pet_hyst import pet_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  surv_entry_t           in_ent,
	input  pos_t                  in_pos,
	output logic                  res_v,
	output logic [PIXEL_BITS-1:0] res_pixel,
	output logic                  res_last
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	surv_entry_t row1_mem [MAX_WIDTH];
	surv_entry_t row2_mem [MAX_WIDTH];
	surv_entry_t rd1_s1, rd2_s1, ent_s1;
	pos_t        pos_s1;
	logic        vld_s1, win_v_q;
	surv_entry_t win_q [3][3];
	pos_t        win_pos_q;
	surv_entry_t dec;
	logic        any_nb;
	logic [AW-1:0] rd_addr, wr_addr;

	assign rd_addr = in_pos.col[AW-1:0];
	assign wr_addr = win_pos_q.col[AW-1:0];

	// earlier neighbors count by their decision, later ones by their keep flag
	always_comb begin
		any_nb = win_q[0][0].fin || win_q[0][1].fin || win_q[0][2].fin ||
		         win_q[1][0].fin || win_q[1][2].keep || win_q[2][0].keep ||
		         win_q[2][1].keep || win_q[2][2].keep;
		dec     = win_q[1][1];
		dec.fin = win_q[1][1].keep && (!win_q[1][1].faint || any_nb);
	end

	// line buffers; the upper row holds decided entries, forwarded on a hit
	always_ff @(posedge clk) begin
		if (in_v) begin
			rd1_s1            <= row1_mem[rd_addr];
			rd2_s1            <= (win_v_q && wr_addr == rd_addr) ? dec : row2_mem[rd_addr];
			row1_mem[rd_addr] <= in_ent;
			ent_s1            <= in_ent;
			pos_s1            <= in_pos;
		end
		if (win_v_q) begin
			row2_mem[wr_addr] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			win_v_q <= 1'b0;
		end else begin
			vld_s1  <= in_v;
			win_v_q <= vld_s1;
		end
	end

	// shift the window; the decided center moves on to the left
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			win_q[0][0] <= win_q[0][1];
			win_q[0][1] <= win_q[0][2];
			win_q[0][2] <= rd2_s1;
			win_q[1][0] <= win_v_q ? dec : win_q[1][1];
			win_q[1][1] <= win_q[1][2];
			win_q[1][2] <= rd1_s1;
			win_q[2][0] <= win_q[2][1];
			win_q[2][1] <= win_q[2][2];
			win_q[2][2] <= ent_s1;
			win_pos_q   <= center_of(pos_s1);
		end else if (win_v_q) begin
			win_q[1][1] <= dec;
		end
	end

	assign res_v     = win_v_q && win_pos_q.res;
	assign res_pixel = dec.fin ? dec.grey : '0;
	assign res_last  = win_pos_q.last;

endmodule

FILE: src/prewitt_edge_thinning_top.sv
// Prewitt edge thinning: takes one pixel or flush tick per clock while in_stall
// is low and gives one result per pixel in raster order. A pixel goes through
// three line-buffered 3x3 windows (gradient, suppression, hysteresis), so a
// result reaches the output FIFO 3*W+3 positions after its own pixel. Flush
// ticks after the last pixel drain one result each; for a three-row frame the
// first one holds the input while the empty positions before its result pass.
// Input is stalled while eight results are reserved in the output FIFO. Line
// buffers need no clearing: every entry read for a kept decision was written
// in the same frame.
module prewitt_edge_thinning_top import pet_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic [PIXEL_BITS-1:0]    pixel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [PIXEL_BITS-1:0]    out_pixel,
	output logic                     out_last,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam logic [GEO_BITS-1:0] MAXW_G = GEO_BITS'(MAX_WIDTH);
	localparam logic [GEO_BITS-1:0] MAXH_G = GEO_BITS'(MAX_HEIGHT);
	localparam logic [GEO_BITS-1:0] MIN_G  = GEO_BITS'(3);

	typedef struct packed {
		logic                  last;
		logic [PIXEL_BITS-1:0] pixel;
	} res_t;

	// configuration registers
	logic [THR_BITS-1:0]  width_q, low_q, high_q;
	logic [GEO_BITS-1:0]  height_q;
	logic [THR2_BITS-1:0] low2_q, high2_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= THR_BITS'(640);
			height_q <= GEO_BITS'(480);
			low_q    <= THR_BITS'(60);
			high_q   <= THR_BITS'(100);
			low2_q   <= THR2_BITS'(3600);
			high2_q  <= THR2_BITS'(10000);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_WIDTH:  width_q  <= cfg_data[THR_BITS-1:0];
					REG_HEIGHT: height_q <= cfg_data[GEO_BITS-1:0];
					REG_LOW:    low_q    <= cfg_data[THR_BITS-1:0];
					REG_HIGH:   high_q   <= cfg_data[THR_BITS-1:0];
					default: ;
				endcase
			end
			low2_q  <= low_q * low_q;
			high2_q <= high_q * high_q;
		end
	end

	// clamp the geometry seen at frame start
	logic [GEO_BITS-1:0] cw, ch;
	logic [25:0]         cprod;

	always_comb begin
		cw = {2'b0, width_q};
		if (cw < MIN_G) cw = MIN_G;
		else if (cw > MAXW_G) cw = MAXW_G;
		ch = height_q;
		if (ch < MIN_G) ch = MIN_G;
		else if (ch > MAXH_G) ch = MAXH_G;
	end
	assign cprod = cw * ch;

	// position control
	logic [POS_BITS-1:0] t_q, total_q, rstart_q, end_q;
	logic [GEO_BITS-1:0] w_q, h_q, geo_w, geo_h;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                flush_q;
	logic [FIFO_AW:0]    resv_q;
	logic                full, t_zero, in_xfer, adv_px, adv_fl, adv, res, last;
	logic                pop;
	logic [POS_BITS-1:0] c3w;

	assign full    = (resv_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign in_stall = flush_q || full;
	assign in_xfer = in_valid && !in_stall;
	assign t_zero  = (t_q == '0);
	assign adv_px  = in_xfer && !kind && (t_zero || t_q < total_q);
	assign adv_fl  = in_xfer && !t_zero && (t_q >= total_q);
	assign adv     = adv_px || adv_fl || (flush_q && !full);
	assign res     = adv && !t_zero && (t_q >= rstart_q);
	assign last    = res && (t_q == end_q);
	assign geo_w   = t_zero ? cw : w_q;
	assign geo_h   = t_zero ? ch : h_q;
	assign c3w     = POS_BITS'({cw, 1'b0}) + POS_BITS'(cw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q      <= '0;
			col_q    <= '0;
			row_q    <= '0;
			flush_q  <= 1'b0;
			w_q      <= MIN_G;
			h_q      <= MIN_G;
			total_q  <= POS_BITS'(9);
			rstart_q <= POS_BITS'(12);
			end_q    <= POS_BITS'(20);
		end else begin
			// latch geometry on the first pixel of a frame
			if (adv_px && t_zero) begin
				w_q      <= cw;
				h_q      <= ch;
				total_q  <= cprod[POS_BITS-1:0];
				rstart_q <= c3w + POS_BITS'(3);
				end_q    <= cprod[POS_BITS-1:0] + c3w + POS_BITS'(2);
			end
			if (adv) begin
				if (last) begin
					t_q   <= '0;
					col_q <= '0;
					row_q <= '0;
				end else begin
					t_q <= t_q + POS_BITS'(1);
					if (({1'b0, col_q} + GEO_BITS'(1)) == geo_w) begin
						col_q <= '0;
						row_q <= row_q + ROW_BITS'(1);
					end else begin
						col_q <= col_q + COL_BITS'(1);
					end
				end
			end
			// hold the input until a drain step yields its result
			if (adv_fl && !res) flush_q <= 1'b1;
			else if (flush_q && res) flush_q <= 1'b0;
		end
	end

	// stage 1: pixel window and gradient
	pos_t                  pos0, pos1, pos2;
	logic [PIXEL_BITS-1:0] pix0;
	logic [PIXEL_BITS-1:0] pwin [3][3];
	logic                  v1, v2;
	mag_entry_t            mag1;

	always_comb begin
		pos0.w    = geo_w;
		pos0.h    = geo_h;
		pos0.col  = col_q;
		pos0.row  = $signed(row_q);
		pos0.res  = res;
		pos0.last = last;
	end
	assign pix0 = adv_px ? pixel : '0;

	pet_window #(.MAX_WIDTH(MAX_WIDTH), .DATA_W(PIXEL_BITS)) u_pix_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (adv),
		.in_data (pix0),
		.in_pos  (pos0),
		.win_v   (v1),
		.win     (pwin),
		.win_pos (pos1)
	);

	pet_grad u_grad (
		.px  (pwin),
		.pos (pos1),
		.ent (mag1)
	);

	// stage 2: magnitude window and suppression
	localparam int MAG_ENT_W = $bits(mag_entry_t);
	logic [MAG_ENT_W-1:0] mwin_raw [3][3];
	mag_entry_t           mwin [3][3];
	surv_entry_t          surv2;

	pet_window #(.MAX_WIDTH(MAX_WIDTH), .DATA_W(MAG_ENT_W)) u_mag_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v1),
		.in_data (mag1),
		.in_pos  (pos1),
		.win_v   (v2),
		.win     (mwin_raw),
		.win_pos (pos2)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mwin[r][c] = mag_entry_t'(mwin_raw[r][c]);
			end
		end
	end

	pet_nms u_nms (
		.mw    (mwin),
		.pos   (pos2),
		.low2  (low2_q),
		.high2 (high2_q),
		.ent   (surv2)
	);

	// stage 3: hysteresis
	logic                  rv;
	logic [PIXEL_BITS-1:0] rpix;
	logic                  rlast;

	pet_hyst #(.MAX_WIDTH(MAX_WIDTH)) u_hyst (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_v      (v2),
		.in_ent    (surv2),
		.in_pos    (pos2),
		.res_v     (rv),
		.res_pixel (rpix),
		.res_last  (rlast)
	);

	// output FIFO with slots reserved at issue
	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_pixel = fifo_q[rd_ptr_q].pixel;
	assign out_last  = fifo_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (rv) begin
			fifo_q[wr_ptr_q] <= '{last: rlast, pixel: rpix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			resv_q   <= '0;
		end else begin
			if (rv) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(rv) - (FIFO_AW+1)'(pop);
			resv_q  <= resv_q + (FIFO_AW+1)'(res) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

FILE: src/pet_checker.sv
module pet_checker import pet_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_BITS-1:0] out_pixel,
	input logic                  out_last,
	input logic                  cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_last))
		else $error("stalled result changed");

	// the register port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// a frame holds at least nine results, so two frame ends never follow
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_last |=> !(out_valid && out_last))
		else $error("frame end on two consecutive results");

endmodule

bind prewitt_edge_thinning_top pet_checker u_pet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_pixel (out_pixel),
	.out_last  (out_last),
	.cfg_ready (cfg_ready)
);

FILE: tb/prewitt_edge_thinning_top_tb.sv
`timescale 1ns / 100ps

module prewitt_edge_thinning_top_tb;
	import pet_pkg::*;

	localparam int MAXW      = 1024;
	localparam int MAXH      = 4096;
	localparam int MRING     = 2 * MAXW + 4;
	localparam int PRING     = 4 * MAXW + 4;
	localparam int LIMIT     = 3000000;
	localparam int SETTLE    = 24;

	typedef struct {
		logic [PIXEL_BITS-1:0] pix;
		logic                  last;
	} edge_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = 1'b0;
	logic [PIXEL_BITS-1:0]    pixel = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [PIXEL_BITS-1:0]    out_pixel;
	logic                     out_last;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [1:0]               cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	prewitt_edge_thinning_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .pixel(pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_pixel(out_pixel), .out_last(out_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// edge detector shadow state
	logic [7:0]          grey_ring [PRING];
	logic [MAG_BITS-1:0] mag_ring  [MRING];
	sector_t             dir_ring  [MRING];
	logic [2:0]          flag_ring [MRING];
	int unsigned pushed, fw, fh;
	int unsigned reg_w, reg_h, reg_lo, reg_hi;

	edge_result_t expected_q [$];
	int  errors = 0;
	int  checked = 0;
	int  frames = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;

	function automatic int unsigned grey_at(int r, int c);
		int unsigned p;
		if (r < 0 || c < 0 || r >= int'(fh) || c >= int'(fw))
			return 0;
		p = r * fw + c;
		if (p >= pushed)
			return 0;
		return grey_ring[p % PRING];
	endfunction

	function automatic bit is_border(int unsigned p);
		int unsigned r, c;
		r = p / fw;
		c = p % fw;
		return r == 0 || r == fh - 1 || c == 0 || c == fw - 1;
	endfunction

	function automatic void grad_at(int unsigned p);
		int r, c, gx, gy, ax, ay, s2;
		sector_t sec;
		r = p / fw;
		c = p % fw;
		gx = 0;
		gy = 0;
		for (int d = -1; d <= 1; d++) begin
			gx += int'(grey_at(r + d, c + 1)) - int'(grey_at(r + d, c - 1));
			gy += int'(grey_at(r + 1, c + d)) - int'(grey_at(r - 1, c + d));
		end
		ax = gx < 0 ? -gx : gx;
		ay = gy < 0 ? -gy : gy;
		s2 = (ax + ay) * (ax + ay);
		if (ax == 0)
			sec = SECT_VERT;
		else if (s2 < 2 * ax * ax)
			sec = SECT_HORZ;
		else if (s2 < 2 * ay * ay)
			sec = SECT_VERT;
		else
			sec = ((gx > 0) == (gy > 0)) ? SECT_DIAG : SECT_ANTI;
		mag_ring[p % MRING] = MAG_BITS'(ax * ax + ay * ay);
		dir_ring[p % MRING] = sec;
	endfunction

	function automatic void suppress_at(int unsigned p);
		int unsigned g, m2, n1, n2, l2, h2, lo, hi;
		bit keep, faint;
		g = grey_ring[p % PRING];
		if (is_border(p)) begin
			flag_ring[p % MRING] = {2'b00, g != 0};
		end else begin
			m2 = mag_ring[p % MRING];
			case (dir_ring[p % MRING])
				SECT_HORZ: begin lo = p - 1;      hi = p + 1;      end
				SECT_VERT: begin lo = p - fw;     hi = p + fw;     end
				SECT_DIAG: begin lo = p - fw - 1; hi = p + fw + 1; end
				default:   begin lo = p - fw + 1; hi = p + fw - 1; end
			endcase
			n1 = mag_ring[lo % MRING];
			n2 = mag_ring[hi % MRING];
			l2 = reg_lo * reg_lo;
			h2 = reg_hi * reg_hi;
			keep = !(m2 < n1 || m2 < n2) && !(m2 < l2) && g != 0;
			faint = m2 > l2 && m2 < h2;
			flag_ring[p % MRING] = {1'b0, faint, keep};
		end
	endfunction

	function automatic logic [7:0] decide_at(int unsigned p);
		logic [2:0] f;
		bit fin, any;
		int unsigned prior [4];
		int unsigned later [4];
		f = flag_ring[p % MRING];
		fin = f[0];
		if (fin && f[1]) begin
			prior = '{p - fw - 1, p - fw, p - fw + 1, p - 1};
			later = '{p + 1, p + fw - 1, p + fw, p + fw + 1};
			any = 1'b0;
			for (int k = 0; k < 4; k++) begin
				if (flag_ring[prior[k] % MRING][2]) any = 1'b1;
				if (flag_ring[later[k] % MRING][0]) any = 1'b1;
			end
			fin = any;
		end
		flag_ring[p % MRING] = {fin, f[1:0]};
		return fin ? grey_ring[p % PRING] : 8'd0;
	endfunction

	// advance all three windows by one position
	function automatic bit advance_edges(output edge_result_t r);
		longint t, stp, m, s, h, total;
		total = fw * fh;
		t = pushed;
		stp = fw + 1;
		pushed++;
		m = t - stp;
		s = m - stp;
		h = s - stp;
		if (m >= 0 && m < total) grad_at(int'(m));
		if (s >= 0 && s < total) suppress_at(int'(s));
		if (h < 0 || h >= total)
			return 1'b0;
		r.pix = decide_at(int'(h));
		r.last = (h == total - 1);
		if (r.last)
			pushed = 0;
		return 1'b1;
	endfunction

	function automatic void predict_edges(logic k, logic [7:0] g);
		edge_result_t r;
		int unsigned total;
		if (!k && pushed == 0) begin
			fw = reg_w < 3 ? 3 : (reg_w > MAXW ? MAXW : reg_w);
			fh = reg_h < 3 ? 3 : (reg_h > MAXH ? MAXH : reg_h);
		end
		total = fw * fh;
		if (!k && pushed < total) begin
			grey_ring[pushed % PRING] = g;
			if (advance_edges(r))
				expected_q.push_back(r);
			return;
		end
		if (pushed < total)
			return;
		while (!advance_edges(r)) ;
		expected_q.push_back(r);
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[prewitt_edge_thinning_top] ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result out_pixel=%0d out_last=%0d", out_pixel, out_last);
				errors++;
			end else begin
				edge_result_t e;
				e = expected_q.pop_front();
				checked++;
				if (out_pixel !== e.pix) begin
					$error("out_pixel expected %0d actual %0d", e.pix, out_pixel);
					errors++;
				end
				if (out_last !== e.last) begin
					$error("out_last expected %0d actual %0d", e.last, out_last);
					errors++;
				end
			end
		end
	end

	// stall the result side in random bursts while idle_on is set
	int stall_left = 0;
	always @(posedge clk) begin
		if (!idle_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(9) == 0) begin
			stall_left <= $urandom_range(6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(logic k, logic [7:0] g);
		if (idle_on && $urandom_range(11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		pixel <= g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_edges(k, g);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_WIDTH:  reg_w  = val & 32'h7FF;
			REG_HEIGHT: reg_h  = val & 32'h1FFF;
			REG_LOW:    reg_lo = val & 32'h7FF;
			default:    reg_hi = val & 32'h7FF;
		endcase
	endtask

	task automatic set_frame(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi);
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_LOW, lo);
		write_reg(REG_HIGH, hi);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_grey(int mode, int unsigned i, int unsigned w);
		case (mode)
			0: return 8'($urandom());
			1: return ($urandom_range(5) == 0) ? 8'd255 : 8'd0;
			2: return ((i % w) < w / 2) ? 8'd20 : 8'd230;
			3: return 8'((i * 37) ^ (i / w) * 11);
			default: return ($urandom_range(3) == 0) ? 8'($urandom()) : 8'd128;
		endcase
	endfunction

	// one whole frame, then drain it with flush ticks
	task automatic run_frame(int mode, bit noise, bit pause);
		int unsigned n;
		n = (reg_w < 3 ? 3 : (reg_w > MAXW ? MAXW : reg_w))
		  * (reg_h < 3 ? 3 : (reg_h > MAXH ? MAXH : reg_h));
		for (int unsigned i = 0; i < n; i++) begin
			if (noise && i != 0 && $urandom_range(29) == 0)
				send_item(1'b1, 8'($urandom()));
			if (pause && i == n / 2) begin
				in_valid <= 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			send_item(1'b0, pick_grey(mode, i, reg_w < 3 ? 3 : reg_w));
		end
		while (pushed != 0)
			send_item(noise && $urandom_range(3) == 0 ? 1'b0 : 1'b1, 8'($urandom()));
		frames++;
	endtask

	task automatic test_directed();
		send_item(1'b1, 8'hFF);
		set_frame(3, 3, 0, 0);
		send_item(1'b0, 8'd0);   send_item(1'b0, 8'd255); send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd255); send_item(1'b0, 8'd255); send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd0);   send_item(1'b0, 8'd255); send_item(1'b0, 8'd170);
		while (pushed != 0) send_item(1'b1, 8'h55);
		frames++;
		set_frame(0, 0, 1083, 1083);
		run_frame(0, 1'b0, 1'b0);
		set_frame(5, 4, 40, 200);
		run_frame(1, 1'b1, 1'b0);
	endtask

	task automatic test_geometry_extremes();
		set_frame(40, 0, 30, 90);
		run_frame(3, 1'b0, 1'b0);
		set_frame(0, 30, 10, 1083);
		run_frame(0, 1'b0, 1'b0);
	endtask

	task automatic test_random_frames(int count);
		for (int f = 0; f < count; f++) begin
			set_frame($urandom_range(9, 3), $urandom_range(8, 3),
				$urandom_range(3) == 0 ? $urandom_range(1083) : $urandom_range(120),
				$urandom_range(3) == 0 ? $urandom_range(1083) : $urandom_range(400));
			run_frame($urandom_range(4), 1'b1, 1'b0);
		end
	endtask

	task automatic test_pressure();
		set_frame(6, 5, 50, 150);
		run_frame(0, 1'b0, 1'b1);
	endtask

	initial begin
		reg_w = 640;
		reg_h = 480;
		reg_lo = 60;
		reg_hi = 100;
		pushed = 0;
		fw = 3;
		fh = 3;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_geometry_extremes();
		test_pressure();
		test_random_frames(30);
		idle_on = 1'b0;
		test_random_frames(5);
		wait_idle();
		$display("covered %0d frames, %0d results checked, undersized geometry and extreme thresholds",
			frames, checked);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("[prewitt_edge_thinning_top] OK");
		end else begin
			$display("[prewitt_edge_thinning_top] ERROR");
		end
		$finish;
	end

endmodule
